// File: hw/rtl/wtl_pkg.sv
package wtl_pkg;

	typedef logic [2:0][31:0] wtl_vec_t;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [31:0] goal_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] ext_x;
		logic signed [31:0] ext_y;
		logic signed [31:0] ext_z;
	} wtl_in_t;

	typedef struct packed {
		logic signed [31:0] thrust_x;
		logic signed [31:0] thrust_y;
		logic signed [31:0] thrust_z;
		logic               speed_capped;
		logic [1:0]         thrust_adjust;
	} wtl_out_t;

	typedef enum logic [2:0] {
		CFG_MAX_SPEED,
		CFG_CLOSE_RANGE,
		CFG_NEAR_GAIN,
		CFG_INV_TIMESTEP,
		CFG_MAX_THRUST,
		CFG_THRUST_FLOOR
	} wtl_cfg_t;

	typedef enum logic [1:0] {
		ADJ_NONE,
		ADJ_MAX,
		ADJ_MIN,
		ADJ_ZERO
	} wtl_adj_t;

	localparam logic [30:0] MAX_SPEED_RST    = 31'd262144;
	localparam logic [30:0] CLOSE_RANGE_RST  = 31'd65536;
	localparam logic [30:0] NEAR_GAIN_RST    = 31'd262144;
	localparam logic [30:0] INV_TIMESTEP_RST = 31'd8192000;
	localparam logic [30:0] MAX_THRUST_RST   = 31'd1310720;
	localparam logic [30:0] THRUST_FLOOR_RST = 31'd65536;

	// a: vector under test, vel and ext ride along
	typedef struct packed {
		wtl_vec_t a;
		wtl_vec_t vel;
		wtl_vec_t ext;
	} wtl_kin_t;

	typedef struct packed {
		logic     cap;
		wtl_kin_t kin;
	} wtl_cpay_t;

	typedef struct packed {
		logic     cap;
		wtl_vec_t t;
	} wtl_tv_t;

	typedef struct packed {
		logic     cap;
		wtl_adj_t adj;
		wtl_vec_t t;
	} wtl_tpay_t;

	function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] df;
		logic [31:0] r;
		df = {a[31], a} - {b[31], b};
		if (df[32] != df[31]) begin
			r = df[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r = df[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

	// signed result from magnitude and sign, saturated
	function automatic logic [31:0] apply_sat(logic [62:0] q, logic neg);
		logic [31:0] r;
		if (neg) begin
			if (q > 63'h8000_0000) begin
				r = 32'h8000_0000;
			end else begin
				r = ~q[31:0] + 32'd1;
			end
		end else if (q > 63'h7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else begin
			r = q[31:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/waypoint_thrust_limiter_top.sv
// channel  | handshake                 | payload
// in       | in_valid / in_stall       | in_data  (wtl_in_t)
// out      | out_valid / out_stall     | out_data (wtl_out_t)
// cfg      | cfg_we                    | cfg_index, cfg_data
// one transaction per cycle sustained while the skid register is empty
// the datapath holds three pipelined square roots and two pipelined dividers
// arst_n clears all valid bits and loads the register defaults
// out_stall holds the whole pipeline once the skid register fills
// in_stall is the registered skid-full flag
module waypoint_thrust_limiter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wtl_pkg::wtl_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output wtl_pkg::wtl_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [30:0]       cfg_data
);
	import wtl_pkg::*;

	localparam int DSTEPS = 31;
	localparam int DPW    = $bits(wtl_cpay_t);
	localparam int TPW    = $bits(wtl_tpay_t);

	logic [30:0] max_speed_q, close_range_q, near_gain_q;
	logic [30:0] inv_timestep_q, max_thrust_q, thrust_floor_q;

	logic adv;

	logic     vld_s1;
	wtl_kin_t kin_s1;

	logic     n1_vld;
	logic [31:0] n1_mag;
	wtl_kin_t n1_pay;
	wtl_vec_t n1_in;

	logic        vld_s2;
	logic [30:0] gain_s2;
	wtl_kin_t    kin_s2;

	logic             vld_s3;
	logic [2:0][62:0] prod_s3;
	logic [2:0]       neg_s3;
	wtl_vec_t         vel_s3, ext_s3;

	logic     vld_s4;
	wtl_kin_t kin_s4;
	wtl_vec_t n2_in;

	logic        n2_vld;
	logic [31:0] n2_mag;
	wtl_kin_t    n2_pay;

	logic             ld_vld [2];
	logic [2:0][62:0] ld_num [2];
	logic [31:0]      ld_den [2];
	logic [DPW-1:0]   ld_pay [2];

	logic             dvld_sn [2][DSTEPS+1];
	logic [2:0][62:0] dnum_sn [2][DSTEPS+1];
	logic [2:0][31:0] drem_sn [2][DSTEPS+1];
	logic [2:0][30:0] dquo_sn [2][DSTEPS+1];
	logic [31:0]      dden_sn [2][DSTEPS+1];
	logic [DPW-1:0]   dpay_sn [2][DSTEPS+1];

	wtl_cpay_t cp;
	logic      vld_s5, cap_s5;
	wtl_vec_t  vc_s5, vel_s5, ext_s5;

	logic     vld_s6, cap_s6;
	wtl_vec_t dv_s6, ext_s6;

	logic             vld_s7, cap_s7;
	logic [2:0][62:0] prod_s7;
	logic [2:0]       neg_s7;
	wtl_vec_t         ext_s7;

	logic     vld_s8, cap_s8;
	wtl_vec_t m_s8, ext_s8;

	logic     vld_s9;
	wtl_tv_t  tv_s9;
	wtl_vec_t n3_in;

	logic        n3_vld;
	logic [31:0] n3_mag;
	wtl_tv_t     n3_pay;

	wtl_adj_t    adj_c;
	logic [30:0] lim_c;

	logic        vld_s10;
	logic [30:0] lim_s10;
	logic [31:0] tm_s10;
	wtl_tpay_t   tp_s10;

	wtl_tpay_t tp;
	wtl_out_t  fin;
	logic      fin_vld;

	logic     o_vld_q, sk_vld_q;
	wtl_out_t o_dat_q, sk_dat_q;

	assign adv = !sk_vld_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q    <= MAX_SPEED_RST;
			close_range_q  <= CLOSE_RANGE_RST;
			near_gain_q    <= NEAR_GAIN_RST;
			inv_timestep_q <= INV_TIMESTEP_RST;
			max_thrust_q   <= MAX_THRUST_RST;
			thrust_floor_q <= THRUST_FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_SPEED:    max_speed_q    <= cfg_data;
				CFG_CLOSE_RANGE:  close_range_q  <= cfg_data;
				CFG_NEAR_GAIN:    near_gain_q    <= cfg_data;
				CFG_INV_TIMESTEP: inv_timestep_q <= cfg_data;
				CFG_MAX_THRUST:   max_thrust_q   <= cfg_data;
				CFG_THRUST_FLOOR: thrust_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position error, distance
	always_ff @(posedge clk) begin
		if (adv) begin
			kin_s1.a[0]   <= sub_sat(in_data.goal_x, in_data.pos_x);
			kin_s1.a[1]   <= sub_sat(in_data.goal_y, in_data.pos_y);
			kin_s1.a[2]   <= sub_sat(in_data.goal_z, in_data.pos_z);
			kin_s1.vel[0] <= in_data.vel_x;
			kin_s1.vel[1] <= in_data.vel_y;
			kin_s1.vel[2] <= in_data.vel_z;
			kin_s1.ext[0] <= in_data.ext_x;
			kin_s1.ext[1] <= in_data.ext_y;
			kin_s1.ext[2] <= in_data.ext_z;
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			n1_in[l] = mag32(kin_s1.a[l]);
			n2_in[l] = mag32(kin_s4.a[l]);
			n3_in[l] = mag32(tv_s9.t[l]);
		end
	end

	wtl_norm #(.PW($bits(wtl_kin_t))) u_norm_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s1),
		.in_mag   (n1_in),
		.in_pay   (kin_s1),
		.out_valid(n1_vld),
		.out_mag  (n1_mag),
		.out_pay  (n1_pay)
	);

	// preferred velocity
	always_ff @(posedge clk) begin
		if (adv) begin
			gain_s2 <= (n1_mag < {1'b0, close_range_q}) ? near_gain_q : inv_timestep_q;
			kin_s2  <= n1_pay;
			for (int l = 0; l < 3; l++) begin
				prod_s3[l]  <= 63'(mag32(kin_s2.a[l])) * 63'(gain_s2);
				neg_s3[l]   <= kin_s2.a[l][31];
				kin_s4.a[l] <= apply_sat(prod_s3[l] >> FRAC_BITS, neg_s3[l]);
			end
			vel_s3     <= kin_s2.vel;
			ext_s3     <= kin_s2.ext;
			kin_s4.vel <= vel_s3;
			kin_s4.ext <= ext_s3;
		end
	end

	wtl_norm #(.PW($bits(wtl_kin_t))) u_norm_speed (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s4),
		.in_mag   (n2_in),
		.in_pay   (kin_s4),
		.out_valid(n2_vld),
		.out_mag  (n2_mag),
		.out_pay  (n2_pay)
	);

	// divider loads: speed cap and thrust limit
	always_comb begin
		ld_vld[0] = n2_vld;
		ld_den[0] = n2_mag;
		ld_pay[0] = {n2_mag > {1'b0, max_speed_q}, n2_pay};
		ld_vld[1] = vld_s10;
		ld_den[1] = tm_s10;
		ld_pay[1] = DPW'(tp_s10);
		for (int l = 0; l < 3; l++) begin
			ld_num[0][l] = 63'(mag32(n2_pay.a[l])) * 63'(max_speed_q);
			ld_num[1][l] = 63'(mag32(tp_s10.t[l])) * 63'(lim_s10);
		end
	end

	for (genvar u = 0; u < 2; u++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_sn[u][0] <= 1'b0;
			end else if (adv) begin
				dvld_sn[u][0] <= ld_vld[u];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dnum_sn[u][0] <= ld_num[u];
				for (int l = 0; l < 3; l++) begin
					drem_sn[u][0][l] <= ld_num[u][l][62:31];
				end
				dquo_sn[u][0] <= '0;
				dden_sn[u][0] <= ld_den[u];
				dpay_sn[u][0] <= ld_pay[u];
			end
		end

		// one quotient bit per stage
		for (genvar k = 0; k < DSTEPS; k++) begin : g_step
			logic [2:0][31:0] rem_nx;
			logic [2:0]       ge;

			always_comb begin
				logic [32:0] r;
				for (int l = 0; l < 3; l++) begin
					r         = {drem_sn[u][k][l], dnum_sn[u][k][l][30-k]};
					ge[l]     = r >= {1'b0, dden_sn[u][k]};
					rem_nx[l] = ge[l] ? 32'(r - {1'b0, dden_sn[u][k]}) : r[31:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dvld_sn[u][k+1] <= 1'b0;
				end else if (adv) begin
					dvld_sn[u][k+1] <= dvld_sn[u][k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dnum_sn[u][k+1] <= dnum_sn[u][k];
					drem_sn[u][k+1] <= rem_nx;
					for (int l = 0; l < 3; l++) begin
						dquo_sn[u][k+1][l] <= {dquo_sn[u][k][l][29:0], ge[l]};
					end
					dden_sn[u][k+1] <= dden_sn[u][k];
					dpay_sn[u][k+1] <= dpay_sn[u][k];
				end
			end
		end
	end

	assign cp = wtl_cpay_t'(dpay_sn[0][DSTEPS]);

	// capped velocity, velocity error, thrust
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				vc_s5[l]    <= cp.cap ?
					apply_sat(63'(dquo_sn[0][DSTEPS][l]), cp.kin.a[l][31]) : cp.kin.a[l];
				dv_s6[l]    <= sub_sat(vc_s5[l], vel_s5[l]);
				prod_s7[l]  <= 63'(mag32(dv_s6[l])) * 63'(inv_timestep_q);
				neg_s7[l]   <= dv_s6[l][31];
				m_s8[l]     <= apply_sat(prod_s7[l] >> FRAC_BITS, neg_s7[l]);
				tv_s9.t[l]  <= sub_sat(m_s8[l], ext_s8[l]);
			end
			cap_s5    <= cp.cap;
			vel_s5    <= cp.kin.vel;
			ext_s5    <= cp.kin.ext;
			cap_s6    <= cap_s5;
			ext_s6    <= ext_s5;
			cap_s7    <= cap_s6;
			ext_s7    <= ext_s6;
			cap_s8    <= cap_s7;
			ext_s8    <= ext_s7;
			tv_s9.cap <= cap_s8;
		end
	end

	wtl_norm #(.PW($bits(wtl_tv_t))) u_norm_thrust (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s9),
		.in_mag   (n3_in),
		.in_pay   (tv_s9),
		.out_valid(n3_vld),
		.out_mag  (n3_mag),
		.out_pay  (n3_pay)
	);

	// thrust limit decision, max test first
	always_comb begin
		adj_c = ADJ_NONE;
		lim_c = max_thrust_q;
		if (n3_mag > {1'b0, max_thrust_q}) begin
			adj_c = ADJ_MAX;
		end else if (n3_mag < {1'b0, thrust_floor_q}) begin
			lim_c = thrust_floor_q;
			adj_c = (n3_mag == '0) ? ADJ_ZERO : ADJ_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lim_s10    <= lim_c;
			tm_s10     <= n3_mag;
			tp_s10.cap <= n3_pay.cap;
			tp_s10.adj <= adj_c;
			tp_s10.t   <= n3_pay.t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= n1_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= dvld_sn[0][DSTEPS];
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= n3_vld;
		end
	end

	// final selection
	always_comb begin
		logic [2:0][31:0] th;
		tp      = wtl_tpay_t'(dpay_sn[1][DSTEPS][TPW-1:0]);
		fin_vld = dvld_sn[1][DSTEPS];
		for (int l = 0; l < 3; l++) begin
			case (tp.adj)
				ADJ_MAX, ADJ_MIN: th[l] = apply_sat(63'(dquo_sn[1][DSTEPS][l]), tp.t[l][31]);
				ADJ_ZERO:         th[l] = '0;
				default:          th[l] = tp.t[l];
			endcase
		end
		fin.thrust_x      = th[0];
		fin.thrust_y      = th[1];
		fin.thrust_z      = th[2];
		fin.speed_capped  = tp.cap;
		fin.thrust_adjust = tp.adj;
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q  <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (!o_vld_q || !out_stall) begin
			if (sk_vld_q) begin
				o_vld_q  <= 1'b1;
				sk_vld_q <= 1'b0;
			end else begin
				o_vld_q <= fin_vld;
			end
		end else if (adv && fin_vld) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_vld_q || !out_stall) begin
			o_dat_q <= sk_vld_q ? sk_dat_q : fin;
		end else if (adv && fin_vld) begin
			sk_dat_q <= fin;
		end
	end

	assign in_stall  = sk_vld_q;
	assign out_valid = o_vld_q;
	assign out_data  = o_dat_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |-> o_vld_q)
		else $error("skid holds a transaction while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_vld_q) |-> $past(o_vld_q && out_stall))
		else $error("skid filled without a stalled output");

	a_zero_thrust: assert property (@(posedge clk) disable iff (!arst_n)
		(o_vld_q && o_dat_q.thrust_adjust == ADJ_ZERO) |->
		(o_dat_q.thrust_x == '0 && o_dat_q.thrust_y == '0 && o_dat_q.thrust_z == '0))
		else $error("zero magnitude flag with nonzero thrust");

endmodule

// File: hw/rtl/wtl_norm.sv
module wtl_norm #(
	parameter int PW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  wtl_pkg::wtl_vec_t in_mag,
	input  logic [PW-1:0]     in_pay,
	output logic              out_valid,
	output logic [31:0]       out_mag,
	output logic [PW-1:0]     out_pay
);
	import wtl_pkg::*;

	localparam int STEPS = 32;

	logic              vld_s1;
	logic [2:0][63:0]  sq_s1;
	logic [PW-1:0]     pay_s1;

	logic              vld_sn  [STEPS+1];
	logic [63:0]       rad_sn  [STEPS+1];
	logic [33:0]       rem_sn  [STEPS+1];
	logic [31:0]       root_sn [STEPS+1];
	logic [PW-1:0]     pay_sn  [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_sn[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_sn[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s1[l] <= 64'(in_mag[l]) * 64'(in_mag[l]);
			end
			pay_s1     <= in_pay;
			rad_sn[0]  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rem_sn[0]  <= '0;
			root_sn[0] <= '0;
			pay_sn[0]  <= pay_s1;
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		always_comb begin
			cur   = {rem_sn[k], rad_sn[k][63:62]};
			trial = {2'b00, root_sn[k], 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else if (en) begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sn[k+1] <= {rad_sn[k][61:0], 2'b00};
				pay_sn[k+1] <= pay_sn[k];
				if (ge) begin
					rem_sn[k+1]  <= 34'(cur - trial);
					root_sn[k+1] <= {root_sn[k][30:0], 1'b1};
				end else begin
					rem_sn[k+1]  <= cur[33:0];
					root_sn[k+1] <= {root_sn[k][30:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_sn[STEPS];
	assign out_mag   = root_sn[STEPS];
	assign out_pay   = pay_sn[STEPS];

endmodule

// File: dv/tb_waypoint_thrust_limiter_top.sv
`timescale 1ns / 1ps

module tb_waypoint_thrust_limiter_top;
	import wtl_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 177;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	wtl_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	wtl_out_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	logic [30:0] r_max_speed, r_close_range, r_near_gain;
	logic [30:0] r_inv_timestep, r_max_thrust, r_thrust_floor;

	wtl_out_t thrust_expected[$];
	int error_count = 0;
	bit hold_off = 1'b0;
	int hold_cycles = 0;
	bit stall_free = 1'b0;

	waypoint_thrust_limiter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic longint abs_of(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint unsigned q;
		q = (longint'(abs_of(a)) * b) >> FRAC;
		return clamp32(a < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint fx_rescale(longint a, longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		q = (longint'(abs_of(a)) * num) / den;
		return clamp32(a < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint unsigned norm3(longint v[3]);
		longint unsigned s, res, b, n;
		s = 0;
		for (int i = 0; i < 3; i++) s += longint'(abs_of(v[i])) * abs_of(v[i]);
		n = s;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic wtl_out_t predict_thrust(wtl_in_t x);
		longint g[3], p[3], vc[3], e[3], d[3], v[3], t[3];
		longint unsigned range_mag, speed, tm;
		longint gain, dv;
		wtl_out_t o;
		g = '{x.goal_x, x.goal_y, x.goal_z};
		p = '{x.pos_x, x.pos_y, x.pos_z};
		vc = '{x.vel_x, x.vel_y, x.vel_z};
		e = '{x.ext_x, x.ext_y, x.ext_z};
		o = '0;
		for (int i = 0; i < 3; i++) d[i] = clamp32(g[i] - p[i]);
		range_mag = norm3(d);
		gain = (range_mag < r_close_range) ? r_near_gain : r_inv_timestep;
		for (int i = 0; i < 3; i++) v[i] = fx_mul(d[i], gain);
		speed = norm3(v);
		if (speed > r_max_speed) begin
			for (int i = 0; i < 3; i++) v[i] = fx_rescale(v[i], r_max_speed, speed);
			o.speed_capped = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			dv = clamp32(v[i] - vc[i]);
			t[i] = clamp32(fx_mul(dv, r_inv_timestep) - e[i]);
		end
		tm = norm3(t);
		o.thrust_adjust = ADJ_NONE;
		if (tm > r_max_thrust) begin
			for (int i = 0; i < 3; i++) t[i] = fx_rescale(t[i], r_max_thrust, tm);
			o.thrust_adjust = ADJ_MAX;
		end else if (tm < r_thrust_floor) begin
			if (tm == 0) begin
				for (int i = 0; i < 3; i++) t[i] = 0;
				o.thrust_adjust = ADJ_ZERO;
			end else begin
				for (int i = 0; i < 3; i++) t[i] = fx_rescale(t[i], r_thrust_floor, tm);
				o.thrust_adjust = ADJ_MIN;
			end
		end
		o.thrust_x = t[0][31:0];
		o.thrust_y = t[1][31:0];
		o.thrust_z = t[2][31:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		error_count++;
	endtask

	// receiver stall pattern and long hold-off
	always @(posedge clk) begin
		if (hold_off) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else if (stall_free) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		wtl_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (thrust_expected.size() == 0) begin
				report_mismatch("unexpected transaction", out_data.thrust_x, '0);
			end else begin
				e = thrust_expected.pop_front();
				if (out_data.thrust_x !== e.thrust_x)
					report_mismatch("thrust_x", out_data.thrust_x, e.thrust_x);
				if (out_data.thrust_y !== e.thrust_y)
					report_mismatch("thrust_y", out_data.thrust_y, e.thrust_y);
				if (out_data.thrust_z !== e.thrust_z)
					report_mismatch("thrust_z", out_data.thrust_z, e.thrust_z);
				if (out_data.speed_capped !== e.speed_capped)
					report_mismatch("speed_capped", 32'(out_data.speed_capped),
						32'(e.speed_capped));
				if (out_data.thrust_adjust !== e.thrust_adjust)
					report_mismatch("thrust_adjust", 32'(out_data.thrust_adjust),
						32'(e.thrust_adjust));
			end
		end
	end

	task automatic send_item(wtl_in_t x);
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		thrust_expected.push_back(predict_thrust(x));
	endtask

	task automatic idle_sender();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_burst(wtl_in_t x);
		send_item(x);
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 6)) idle_sender();
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (thrust_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(wtl_cfg_t idx, logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAX_SPEED: r_max_speed = val;
			CFG_CLOSE_RANGE: r_close_range = val;
			CFG_NEAR_GAIN: r_near_gain = val;
			CFG_INV_TIMESTEP: r_inv_timestep = val;
			CFG_MAX_THRUST: r_max_thrust = val;
			CFG_THRUST_FLOOR: r_thrust_floor = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
			default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
		endcase
	endfunction

	function automatic wtl_in_t rand_item();
		wtl_in_t x;
		x.goal_x = rand_val(); x.goal_y = rand_val(); x.goal_z = rand_val();
		x.pos_x = rand_val(); x.pos_y = rand_val(); x.pos_z = rand_val();
		x.vel_x = rand_val(); x.vel_y = rand_val(); x.vel_z = rand_val();
		x.ext_x = rand_val(); x.ext_y = rand_val(); x.ext_z = rand_val();
		// near the goal often, to hit the close-range law
		if ($urandom_range(0, 2) == 0) begin
			x.pos_x = x.goal_x + ($urandom_range(0, 32'h2_0000) - 32'h1_0000);
			x.pos_y = x.goal_y + ($urandom_range(0, 32'h2_0000) - 32'h1_0000);
			x.pos_z = x.goal_z + ($urandom_range(0, 32'h2_0000) - 32'h1_0000);
		end
		return x;
	endfunction

	task automatic test_directed();
		wtl_in_t x;
		x = '0;
		send_item(x);
		x = '1;
		send_item(x);
		x = '0;
		x.goal_x = 32'h7FFF_FFFF; x.pos_x = 32'h8000_0000;
		x.goal_y = 32'h8000_0000; x.pos_y = 32'h7FFF_FFFF;
		x.vel_z = 32'h8000_0000; x.ext_z = 32'h7FFF_FFFF;
		send_item(x);
		x = '0;
		x.goal_x = 32'h0001_0000;
		send_item(x);
		x = '0;
		x.goal_y = 32'h0000_8000;
		send_item(x);
		x = '0;
		x.goal_z = 32'h0000_0100;
		x.vel_z = 32'h0000_0400;
		send_item(x);
		x = '0;
		x.goal_x = 32'h0000_0001;
		send_item(x);
		x = '0;
		x.ext_x = 32'h0000_8000;
		send_item(x);
		x = '0;
		x.ext_y = 32'h0014_0000;
		send_item(x);
		x = '0;
		x.ext_z = 32'hFFEB_0000;
		send_item(x);
		x = '0;
		x.vel_x = 32'h7FFF_FFFF; x.vel_y = 32'h7FFF_FFFF; x.vel_z = 32'h7FFF_FFFF;
		x.ext_x = 32'h8000_0000; x.ext_y = 32'h8000_0000; x.ext_z = 32'h8000_0000;
		send_item(x);
		drain();
		// zero magnitude with a zero floor, and floor above max
		write_reg(CFG_THRUST_FLOOR, 31'd0);
		x = '0;
		send_item(x);
		x.ext_x = 32'h0000_0010;
		send_item(x);
		drain();
		write_reg(CFG_THRUST_FLOOR, 31'h7FFF_FFFF);
		write_reg(CFG_MAX_THRUST, 31'd65536);
		x = '0;
		x.ext_x = 32'h0000_0100;
		send_item(x);
		x.ext_x = 32'h0100_0000;
		send_item(x);
		drain();
	endtask

	task automatic test_random(int n);
		repeat (n) send_burst(rand_item());
		drain();
	endtask

	task automatic test_back_pressure();
		int target;
		stall_free = 1'b1;
		hold_off = 1'b1;
		target = hold_cycles + LATENCY + 100;
		fork
			repeat (LATENCY + 60) send_item(rand_item());
			begin
				while (hold_cycles < target) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		stall_free = 1'b0;
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(CFG_MAX_SPEED, 31'h7FFF_FFFF);
		write_reg(CFG_CLOSE_RANGE, 31'h7FFF_FFFF);
		write_reg(CFG_NEAR_GAIN, 31'h7FFF_FFFF);
		write_reg(CFG_INV_TIMESTEP, 31'h7FFF_FFFF);
		write_reg(CFG_MAX_THRUST, 31'h7FFF_FFFF);
		write_reg(CFG_THRUST_FLOOR, 31'd0);
		test_random(60);
		write_reg(CFG_MAX_SPEED, 31'd0);
		write_reg(CFG_CLOSE_RANGE, 31'd0);
		write_reg(CFG_NEAR_GAIN, 31'd0);
		write_reg(CFG_INV_TIMESTEP, 31'd0);
		write_reg(CFG_MAX_THRUST, 31'd0);
		write_reg(CFG_THRUST_FLOOR, 31'h7FFF_FFFF);
		test_random(40);
		for (int k = 0; k < 3; k++) begin
			write_reg(CFG_MAX_SPEED, 31'($urandom_range(0, 32'h0100_0000)));
			write_reg(CFG_CLOSE_RANGE, 31'($urandom_range(0, 32'h0010_0000)));
			write_reg(CFG_NEAR_GAIN, 31'($urandom_range(0, 32'h0100_0000)));
			write_reg(CFG_INV_TIMESTEP, 31'($urandom_range(0, 32'h0100_0000)));
			write_reg(CFG_MAX_THRUST, 31'($urandom_range(0, 32'h0200_0000)));
			write_reg(CFG_THRUST_FLOOR, 31'($urandom_range(0, 32'h0004_0000)));
			test_random(40);
		end
		write_reg(CFG_MAX_SPEED, MAX_SPEED_RST);
		write_reg(CFG_CLOSE_RANGE, CLOSE_RANGE_RST);
		write_reg(CFG_NEAR_GAIN, NEAR_GAIN_RST);
		write_reg(CFG_INV_TIMESTEP, INV_TIMESTEP_RST);
		write_reg(CFG_MAX_THRUST, MAX_THRUST_RST);
		write_reg(CFG_THRUST_FLOOR, THRUST_FLOOR_RST);
	endtask

	initial begin
		r_max_speed = MAX_SPEED_RST;
		r_close_range = CLOSE_RANGE_RST;
		r_near_gain = NEAR_GAIN_RST;
		r_inv_timestep = INV_TIMESTEP_RST;
		r_max_thrust = MAX_THRUST_RST;
		r_thrust_floor = THRUST_FLOOR_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_reg(CFG_MAX_THRUST, MAX_THRUST_RST);
		write_reg(CFG_THRUST_FLOOR, THRUST_FLOOR_RST);
		test_random(80);
		test_back_pressure();
		test_config_sweep();
		if (error_count == 0) begin
			$display("tb_waypoint_thrust_limiter_top: done, clean");
		end else begin
			$display("tb_waypoint_thrust_limiter_top: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_waypoint_thrust_limiter_top: done, errors");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/wtl_pkg.sv
hw/rtl/wtl_norm.sv
hw/rtl/waypoint_thrust_limiter_top.sv
dv/tb_waypoint_thrust_limiter_top.sv
